// ===== design/mesh_vertex_dedup_top_macros.svh =====
// Assertion helpers shared by the deduplication block.
// In synthesis the macros expand to nothing.
`ifndef MESH_VERTEX_DEDUP_TOP_MACROS_SVH
`define MESH_VERTEX_DEDUP_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every rising edge outside of reset.
`define MVD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mesh_vertex_dedup: check failed");

// Checks that a condition never becomes true outside of reset.
`define MVD_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mesh_vertex_dedup: forbidden condition seen");

`else

`define MVD_ASSERT(name, clk, rst_n, prop)
`define MVD_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

// ===== design/mvd_pkg.sv =====
`default_nettype none

package mvd_pkg;

    // Default capacity of the unique-corner table.
    localparam int MAX_UNIQUE_DEF = 1024;

    // Field widths fixed by the beat formats.
    localparam int POS_W   = 10;
    localparam int COORD_W = 12;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int KEY_W   = 1 + 2 * COORD_W + POS_W;

    // One triangle corner.
    typedef struct packed {
        logic               start_of_mesh;
        logic [POS_W-1:0]   position_index;
        logic [COORD_W-1:0] skin_s;
        logic [COORD_W-1:0] skin_t;
        logic               on_seam;
        logic               faces_front;
    } corner_beat_t;

    // One merge result.
    typedef struct packed {
        logic [INDEX_W-1:0] merged_index;
        logic               is_new;
        logic               table_full;
        logic [COUNT_W-1:0] unique_count;
    } result_beat_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } mvd_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic search;
        logic finish;
    } mvd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_done;
        logic out_free;
    } mvd_status_t;

endpackage

`default_nettype wire

// ===== design/mvd_ram.sv =====
`default_nettype none

module mvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/mvd_ctrl.sv =====
`default_nettype none

module mvd_ctrl
    import mvd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        corner_valid,
    output logic             corner_stall,
    output mvd_cmd_t         cmd,
    input  wire mvd_status_t status
);

    mvd_state_t state_reg;
    mvd_state_t state_next;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (corner_valid)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (status.search_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output decode.
    always_comb
    begin
        cmd          = '0;
        corner_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                corner_stall = 1'b0;
                cmd.load     = corner_valid;
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/mvd_dp.sv =====
`default_nettype none

module mvd_dp
    import mvd_pkg::*;
#(
    parameter int MAX_UNIQUE = MAX_UNIQUE_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire corner_beat_t corner,
    output logic              result_valid,
    input  wire logic         result_stall,
    output result_beat_t      result,
    input  wire mvd_cmd_t     cmd,
    output mvd_status_t       status
);

    `include "mesh_vertex_dedup_top_macros.svh"

    localparam int ADDR_W = $clog2(MAX_UNIQUE);
    localparam int CNT_W  = $clog2(MAX_UNIQUE + 1);

    // Control registers.
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic              cmp_vld_reg;
    logic              found_reg;
    logic              out_vld_reg;

    // Payload registers.
    logic [KEY_W-1:0]  key_reg;
    logic [ADDR_W-1:0] cmp_idx_reg;
    logic [ADDR_W-1:0] found_idx_reg;
    result_beat_t      out_reg;
    result_beat_t      out_next;

    logic [KEY_W-1:0]  corner_key;
    logic [KEY_W-1:0]  rd_data;
    logic              issue;
    logic              hit_now;
    logic              room;
    logic              do_write;
    logic [ADDR_W-1:0] merged_idx;
    logic [31:0]       merged_wide;
    logic [31:0]       count_wide;

    // Key of the incoming corner: back flag over t, s and position.
    assign corner_key = {corner.on_seam & ~corner.faces_front,
                         corner.skin_t, corner.skin_s, corner.position_index};

    // Search: one read issued and one stored entry compared each cycle.
    assign issue   = cmd.search && (rd_idx_reg != count_reg);
    assign hit_now = cmd.search && cmp_vld_reg && (rd_data == key_reg);

    assign status.search_done = hit_now || ((rd_idx_reg == count_reg) && !cmp_vld_reg);
    assign status.out_free    = !out_vld_reg || !result_stall;

    // Finish: append on a miss when there is room.
    assign room     = count_reg < CNT_W'(MAX_UNIQUE);
    assign do_write = cmd.finish && !found_reg && room;

    always_comb
    begin
        count_next = count_reg;
        merged_idx = '0;
        if (found_reg)
        begin
            merged_idx = found_idx_reg;
        end
        else if (room)
        begin
            merged_idx = count_reg[ADDR_W-1:0];
            count_next = count_reg + CNT_W'(1);
        end
    end

    assign merged_wide = 32'(merged_idx);
    assign count_wide  = 32'(count_next);

    always_comb
    begin
        out_next.merged_index = merged_wide[INDEX_W-1:0];
        out_next.is_new       = !found_reg && room;
        out_next.table_full   = !found_reg && !room;
        out_next.unique_count = count_wide[COUNT_W-1:0];
    end

    mvd_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_UNIQUE)
    ) u_table (
        .clk   (clk),
        .we    (do_write),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (key_reg),
        .raddr (rd_idx_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    // Control state: entry count, search pointers, hit flag, result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (corner.start_of_mesh)
                begin
                    count_reg <= '0;
                end
                rd_idx_reg  <= '0;
                cmp_vld_reg <= 1'b0;
                found_reg   <= 1'b0;
            end
            else if (cmd.search)
            begin
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
                cmp_vld_reg <= issue;
                if (hit_now)
                begin
                    found_reg <= 1'b1;
                end
            end
            else if (cmd.finish)
            begin
                count_reg <= count_next;
            end

            if (cmd.finish)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= corner_key;
        end
        if (issue)
        begin
            cmp_idx_reg <= rd_idx_reg[ADDR_W-1:0];
        end
        if (hit_now)
        begin
            found_idx_reg <= cmp_idx_reg;
        end
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    // The entry count never passes the table capacity.
    `MVD_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(MAX_UNIQUE))
    // The read pointer never runs past the filled part of the table.
    `MVD_ASSERT(a_rd_idx_bound, clk, rst_n, rd_idx_reg <= count_reg)
    // A table write only happens on a miss with room, and grows the count by one.
    `MVD_ASSERT(a_write_grows, clk, rst_n,
        do_write |=> (count_reg == $past(count_reg) + CNT_W'(1)))
    // A matched entry always lies inside the filled part of the table.
    `MVD_ASSERT_NEVER(a_found_range, clk, rst_n,
        cmd.finish && found_reg && (CNT_W'(found_idx_reg) >= count_reg))

endmodule

`default_nettype wire

// ===== design/mesh_vertex_dedup_top.sv =====
// Triangle corner deduplication.
// Input channel: one corner per beat (corner, corner_valid, corner_stall). The
// block forms back = on_seam & ~faces_front and looks up the corner in a table
// of unique corners, in insertion order. start_of_mesh empties the table first.
// Output channel: one result per corner (result, result_valid, result_stall):
// the matching or newly appended index, is_new, table_full and the count.
// The table has a single read port and is scanned one entry per cycle, from
// the first stored entry on; the search ends at the first match or after the
// last stored entry. The block goes idle as the result is written, and
// accepts the next corner while idle.
// One corner is in work at a time; corner_stall is low only while idle.
// The result sits in an output register, so the next corner is accepted while
// a finished result still waits. While result_stall is high, the result holds
// and a newly finished corner waits in its last step until the register frees.
// Reset empties the table at once (the entry count goes to zero); no clearing
// pass is needed.
`default_nettype none

module mesh_vertex_dedup_top
    import mvd_pkg::*;
#(
    parameter int MAX_UNIQUE = MAX_UNIQUE_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         corner_valid,
    output logic              corner_stall,
    input  wire corner_beat_t corner,
    output logic              result_valid,
    input  wire logic         result_stall,
    output result_beat_t      result
);

    mvd_cmd_t    cmd;
    mvd_status_t status;

    // Sequencer.
    mvd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .corner_valid (corner_valid),
        .corner_stall (corner_stall),
        .cmd          (cmd),
        .status       (status)
    );

    // Table, search pointers and result register.
    mvd_dp #(
        .MAX_UNIQUE (MAX_UNIQUE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .corner       (corner),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire
